### rtl/idfs_pkg.sv
// ----------------------------------------------------------------------------
// idfs_pkg
// Shared widths, status codes and structs of the identifier allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package idfs_pkg;

    // Identifier and counter widths
    localparam int ID_W      = 10;
    localparam int CNT_W     = 11;
    localparam int ID_SLOTS  = 1024;
    localparam int STATUS_W  = 3;
    localparam int TDATA_W   = 16;

    // Default upper bound of fresh identifiers
    localparam int DEFAULT_MAX_ID = 1023;

    // Request kinds
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_FRESH     = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_REUSED    = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_FREED     = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 3'd4;

    // One result item
    typedef struct packed {
        logic [ID_W-1:0]     granted_id;
        logic [STATUS_W-1:0] status;
    } res_t;

    // Access to the free stack memory
    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] waddr;
        logic [ID_W-1:0] wdata;
        logic [ID_W-1:0] raddr;
    } stk_req_t;

    // Access to the membership flag memory
    typedef struct packed {
        logic            we;
        logic [ID_W-1:0] waddr;
        logic            wdata;
        logic [ID_W-1:0] raddr;
    } flg_req_t;

endpackage

`default_nettype wire

### rtl/idfs_ram.sv
// ----------------------------------------------------------------------------
// idfs_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module idfs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### rtl/idfs_ctrl.sv
// ----------------------------------------------------------------------------
// idfs_ctrl
// Request sequencer: clears the flag memory after reset, then per request
// reads both memories, decides the result and writes the updates back.
// ----------------------------------------------------------------------------
`default_nettype none

module idfs_ctrl
    import idfs_pkg::*;
#(
    parameter int MAX_ID = DEFAULT_MAX_ID
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    // request side
    input  wire logic            req_valid,
    output logic                 req_ready,
    input  wire logic            req_op,
    input  wire logic [ID_W-1:0] req_id,
    // memories
    output stk_req_t             stk_req,
    input  wire logic [ID_W-1:0] stk_rdata,
    output flg_req_t             flg_req,
    input  wire logic            flg_rdata,
    // result side
    output logic                 res_valid,
    output res_t                 res,
    input  wire logic            res_ready
);

    // Largest fresh identifier: bounded by MAX_ID and by the id width
    localparam int FreshLimitInt = (MAX_ID > ID_SLOTS - 1) ? ID_SLOTS - 1 : MAX_ID;
    localparam logic [CNT_W-1:0] FreshLimit = CNT_W'(FreshLimitInt);
    localparam logic [CNT_W-1:0] SlotsCnt   = CNT_W'(ID_SLOTS);

    localparam logic [1:0] FSM_CLEAR = 2'd0;
    localparam logic [1:0] FSM_IDLE  = 2'd1;
    localparam logic [1:0] FSM_READ  = 2'd2;
    localparam logic [1:0] FSM_WAIT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [ID_W-1:0]  clr_addr_reg, clr_addr_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic [CNT_W-1:0] fresh_reg, fresh_next;
    logic             op_reg, op_next;
    logic [ID_W-1:0]  id_reg, id_next;
    res_t             hold_reg, hold_next;
    res_t             res_cmb;
    logic [CNT_W-1:0] depth_dec;

    assign depth_dec = depth_reg - CNT_W'(1);

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        clr_addr_next = clr_addr_reg;
        depth_next    = depth_reg;
        fresh_next    = fresh_reg;
        op_next       = op_reg;
        id_next       = id_reg;
        hold_next     = hold_reg;
        req_ready     = 1'b0;
        res_valid     = 1'b0;
        res           = hold_reg;
        res_cmb       = '{granted_id: '0, status: STATUS_EXHAUSTED};
        stk_req       = '{we: 1'b0, waddr: depth_reg[ID_W-1:0], wdata: id_reg,
                          raddr: depth_dec[ID_W-1:0]};
        flg_req       = '{we: 1'b0, waddr: id_reg, wdata: 1'b0, raddr: req_id};

        case (state_reg)
            FSM_CLEAR: begin
                // sweep the flag memory to zero
                flg_req.we    = 1'b1;
                flg_req.waddr = clr_addr_reg;
                flg_req.wdata = 1'b0;
                clr_addr_next = clr_addr_reg + ID_W'(1);
                if (&clr_addr_reg) begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_IDLE: begin
                // issue both reads with the request
                req_ready = 1'b1;
                if (req_valid) begin
                    op_next    = req_op;
                    id_next    = req_id;
                    state_next = FSM_READ;
                end
            end
            FSM_READ: begin
                // decide and write back
                if (op_reg == OP_ALLOC) begin
                    if (depth_reg != '0) begin
                        res_cmb       = '{granted_id: stk_rdata, status: STATUS_REUSED};
                        depth_next    = depth_dec;
                        flg_req.we    = 1'b1;
                        flg_req.waddr = stk_rdata;
                        flg_req.wdata = 1'b0;
                    end else if (fresh_reg <= FreshLimit) begin
                        res_cmb    = '{granted_id: fresh_reg[ID_W-1:0], status: STATUS_FRESH};
                        fresh_next = fresh_reg + CNT_W'(1);
                    end else begin
                        res_cmb = '{granted_id: '0, status: STATUS_EXHAUSTED};
                    end
                end else begin
                    if (id_reg == '0 || flg_rdata || depth_reg >= SlotsCnt) begin
                        res_cmb = '{granted_id: '0, status: STATUS_DUPLICATE};
                    end else begin
                        res_cmb       = '{granted_id: '0, status: STATUS_FREED};
                        stk_req.we    = 1'b1;
                        flg_req.we    = 1'b1;
                        flg_req.waddr = id_reg;
                        flg_req.wdata = 1'b1;
                        depth_next    = depth_reg + CNT_W'(1);
                    end
                end
                res_valid = 1'b1;
                res       = res_cmb;
                if (res_ready) begin
                    state_next = FSM_IDLE;
                end else begin
                    hold_next  = res_cmb;
                    state_next = FSM_WAIT;
                end
            end
            FSM_WAIT: begin
                // hold the result until the output stage frees
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FSM_CLEAR;
            clr_addr_reg <= '0;
            depth_reg    <= '0;
            fresh_reg    <= CNT_W'(1);
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            depth_reg    <= depth_next;
            fresh_reg    <= fresh_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        op_reg   <= op_next;
        id_reg   <= id_next;
        hold_reg <= hold_next;
    end

endmodule

`default_nettype wire

### rtl/id_allocator_free_stack.sv
// ----------------------------------------------------------------------------
// id_allocator_free_stack
// Identifier allocator with a LIFO free stack held in synchronous memory.
// ----------------------------------------------------------------------------
// A request is handled in steps: IDLE accepts it and reads the free stack and
// the membership flags, READ decides and writes back, so a new request is taken
// only once the last result has passed to the output stage. After reset the
// block sweeps all 1024 entries of the membership flag memory to zero, during which
// s_tready stays low. Allocation pops the most recently freed id, or hands out
// fresh ids from 1 up to min(MAX_ID, 1023), then answers exhausted. Freeing
// id 0 or an id already on the stack is ignored and reported as a duplicate.
// ----------------------------------------------------------------------------
`default_nettype none

module id_allocator_free_stack
    import idfs_pkg::*;
#(
    parameter int MAX_ID = DEFAULT_MAX_ID
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    // request stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [TDATA_W-1:0] s_tdata,   // [9:0] release_id
    input  wire logic               s_tuser,   // [0] operation
    // result stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [TDATA_W-1:0]      m_tdata,   // [9:0] granted_id
    output logic [STATUS_W-1:0]     m_tuser    // [2:0] status
);

    stk_req_t        stk_req;
    flg_req_t        flg_req;
    logic [ID_W-1:0] stk_rdata;
    logic            flg_rdata;
    logic            res_valid;
    logic            res_ready;
    res_t            res;
    logic            m_tvalid_reg, m_tvalid_next;
    res_t            out_reg, out_next;

    idfs_ram #(
        .WIDTH (ID_W),
        .DEPTH (ID_SLOTS)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (stk_req.we),
        .waddr (stk_req.waddr),
        .wdata (stk_req.wdata),
        .raddr (stk_req.raddr),
        .rdata (stk_rdata)
    );

    idfs_ram #(
        .WIDTH (1),
        .DEPTH (ID_SLOTS)
    ) u_flag_ram (
        .aclk  (aclk),
        .we    (flg_req.we),
        .waddr (flg_req.waddr),
        .wdata (flg_req.wdata),
        .raddr (flg_req.raddr),
        .rdata (flg_rdata)
    );

    idfs_ctrl #(
        .MAX_ID (MAX_ID)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_op    (s_tuser),
        .req_id    (s_tdata[ID_W-1:0]),
        .stk_req   (stk_req),
        .stk_rdata (stk_rdata),
        .flg_req   (flg_req),
        .flg_rdata (flg_rdata),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready)
    );

    // Output register: load a result when empty or being drained
    assign res_ready = !m_tvalid_reg || m_tready;

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        out_next      = out_reg;
        if (res_ready) begin
            m_tvalid_next = res_valid;
            if (res_valid) begin
                out_next = res;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = TDATA_W'(out_reg.granted_id);
    assign m_tuser  = out_reg.status;

endmodule

`default_nettype wire
